### src/qspd_pkg.sv
// shared types, character constants and helpers for the query string percent decoder
package qspd_pkg;

   localparam int COUNT_BITS_DEFAULT  = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_RESULTS         = 5;
   localparam int RESULT_IDX_BITS     = $clog2(MAX_RESULTS);

   localparam logic [7:0] SEPARATOR_RESET = 8'h26;
   localparam logic [7:0] CHAR_PERCENT    = 8'h25;
   localparam logic [7:0] CHAR_PLUS       = 8'h2b;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3d;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CASE_MASK       = 8'hdf;

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] count;
   } result_type;

   // all results caused by one input byte
   typedef struct packed {
      logic [RESULT_IDX_BITS-1:0]   num;
      result_type [MAX_RESULTS-1:0] res;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic [3:0] nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CHAR_UPPER_A) begin
         v = (c & CASE_MASK) - CHAR_UPPER_A + 8'd10;
      end else begin
         v = c - CHAR_ZERO;
      end
      return v[3:0];
   endfunction

endpackage

### src/query_string_percent_decoder_unit.sv
// top level of the query string percent decoder
//
//  channel | handshake             | payload
//  req     | req_valid, req_stall  | req_in_byte, req_last
//  rsp     | rsp_valid, rsp_stall  | rsp_kind, rsp_out_byte, rsp_invalid_count, rsp_last_of_run
//  csr     | csr_wr_en             | csr_wr_data
//
// one byte is taken per cycle while the result queue has room; its results pass through
// the queue and the output register. the back end drives one result per cycle while
// rsp_stall is low, so a byte causing several results holds the output; the queue absorbs it.
// synchronous reset restores the separator to '&' and clears parse state.
// req_stall rises only when the queue is full.
module query_string_percent_decoder_unit #(
   parameter int COUNT_BITS  = qspd_pkg::COUNT_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = qspd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_invalid_count,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   qspd_pkg::queue_status_type queue_status;
   qspd_pkg::bundle_type       push_data;
   qspd_pkg::bundle_type       head;
   logic                       push;
   logic                       pop;

   qspd_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_last     (req_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   qspd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   qspd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .queue_status      (queue_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_invalid_count (rsp_invalid_count),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

### src/qspd_front.sv
// front end: takes raw bytes, tracks parse state and builds the result bundle per byte
module qspd_front #(
   parameter int COUNT_BITS = qspd_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_byte,
   input  logic                        req_last,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data,
   input  qspd_pkg::queue_status_type  queue_status,
   output logic                        push,
   output qspd_pkg::bundle_type        push_data
);

   localparam int IDX_BITS = qspd_pkg::RESULT_IDX_BITS;

   typedef enum logic [1:0] {MODE_IDLE, MODE_KEY, MODE_VAL} mode_type;

   mode_type                                 mode_ff, mode_in;
   logic [1:0]                               pend_cnt_ff, pend_cnt_in;
   logic [7:0]                               pend_digit_ff, pend_digit_in;
   logic [COUNT_BITS-1:0]                    inv_cnt_ff, inv_cnt_in;
   logic [7:0]                               separator_ff;
   logic [qspd_pkg::RESULT_IDX_BITS-1:0]     num;
   qspd_pkg::result_type [qspd_pkg::MAX_RESULTS-1:0] res;
   logic                                     seg_end;
   logic                                     used;
   logic                                     accept;
   logic [7:0]                               c;

   function automatic logic [15:0] count16(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS+15:0] ext;
      ext = {16'd0, v};
      return ext[15:0];
   endfunction

   function automatic qspd_pkg::result_type make_result(input logic [1:0] kind,
                                                         input logic [7:0] data,
                                                         input logic [COUNT_BITS-1:0] v);
      qspd_pkg::result_type r;
      r.kind  = kind;
      r.data  = data;
      r.count = count16(v);
      return r;
   endfunction

   function automatic logic [1:0] data_kind(input mode_type m);
      return (m == MODE_VAL) ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_KEY;
   endfunction

   assign c         = req_in_byte;
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      mode_in       = mode_ff;
      pend_cnt_in   = pend_cnt_ff;
      pend_digit_in = pend_digit_ff;
      inv_cnt_in    = inv_cnt_ff;
      num           = '0;
      res           = '0;
      seg_end       = 1'b0;
      used          = 1'b0;

      if (mode_in == MODE_IDLE) begin
         pend_cnt_in = 2'd0;
         if (c == separator_ff) begin
            // leading separators are skipped
         end else if (c == qspd_pkg::CHAR_EQUAL) begin
            mode_in = MODE_VAL;
         end else begin
            mode_in = MODE_KEY;
            if (c == qspd_pkg::CHAR_PERCENT) begin
               pend_cnt_in = 2'd1;
            end else if (c == qspd_pkg::CHAR_PLUS) begin
               res[num] = make_result(data_kind(mode_in), qspd_pkg::CHAR_SPACE, inv_cnt_in);
               num = num + IDX_BITS'(1);
            end else begin
               res[num] = make_result(data_kind(mode_in), c, inv_cnt_in);
               num = num + IDX_BITS'(1);
            end
         end
      end else begin
         seg_end = (c == separator_ff) || ((mode_in == MODE_KEY) && (c == qspd_pkg::CHAR_EQUAL));
         if ((pend_cnt_in != 2'd0) && !seg_end && qspd_pkg::is_hex(c)) begin
            used = 1'b1;
            if (pend_cnt_in == 2'd1) begin
               pend_cnt_in   = 2'd2;
               pend_digit_in = c;
            end else begin
               res[num] = make_result(data_kind(mode_in),
                                      {qspd_pkg::nibble(pend_digit_in), qspd_pkg::nibble(c)},
                                      inv_cnt_in);
               num = num + IDX_BITS'(1);
               pend_cnt_in   = 2'd0;
               pend_digit_in = 8'd0;
            end
         end else if (pend_cnt_in != 2'd0) begin
            // broken escape: raw percent, then any held digit
            if (inv_cnt_in != '1) begin
               inv_cnt_in = inv_cnt_in + COUNT_BITS'(1);
            end
            res[num] = make_result(data_kind(mode_in), qspd_pkg::CHAR_PERCENT, inv_cnt_in);
            num = num + IDX_BITS'(1);
            if (pend_cnt_in >= 2'd2) begin
               res[num] = make_result(data_kind(mode_in), pend_digit_in, inv_cnt_in);
               num = num + IDX_BITS'(1);
            end
            pend_cnt_in   = 2'd0;
            pend_digit_in = 8'd0;
         end
         if (!used) begin
            if (c == separator_ff) begin
               res[num] = make_result(qspd_pkg::KIND_END, 8'd0, inv_cnt_in);
               num = num + IDX_BITS'(1);
               mode_in = MODE_IDLE;
            end else if ((mode_in == MODE_KEY) && (c == qspd_pkg::CHAR_EQUAL)) begin
               mode_in = MODE_VAL;
            end else if (c == qspd_pkg::CHAR_PERCENT) begin
               pend_cnt_in = 2'd1;
            end else if (c == qspd_pkg::CHAR_PLUS) begin
               res[num] = make_result(data_kind(mode_in), qspd_pkg::CHAR_SPACE, inv_cnt_in);
               num = num + IDX_BITS'(1);
            end else begin
               res[num] = make_result(data_kind(mode_in), c, inv_cnt_in);
               num = num + IDX_BITS'(1);
            end
         end
      end

      if (req_last) begin
         if (pend_cnt_in != 2'd0) begin
            if (inv_cnt_in != '1) begin
               inv_cnt_in = inv_cnt_in + COUNT_BITS'(1);
            end
            res[num] = make_result(data_kind(mode_in), qspd_pkg::CHAR_PERCENT, inv_cnt_in);
            num = num + IDX_BITS'(1);
            if (pend_cnt_in >= 2'd2) begin
               res[num] = make_result(data_kind(mode_in), pend_digit_in, inv_cnt_in);
               num = num + IDX_BITS'(1);
            end
         end
         pend_cnt_in   = 2'd0;
         pend_digit_in = 8'd0;
         if (mode_in != MODE_IDLE) begin
            res[num] = make_result(qspd_pkg::KIND_END, 8'd0, inv_cnt_in);
            num = num + IDX_BITS'(1);
         end
         res[num] = make_result(qspd_pkg::KIND_DONE, 8'd0, inv_cnt_in);
         num = num + IDX_BITS'(1);
         inv_cnt_in = '0;
         mode_in    = MODE_IDLE;
      end
   end

   assign push          = accept && (num != '0);
   assign push_data.num = num;
   assign push_data.res = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         pend_cnt_ff   <= 2'd0;
         pend_digit_ff <= 8'd0;
         inv_cnt_ff    <= '0;
         separator_ff  <= qspd_pkg::SEPARATOR_RESET;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            pend_cnt_ff   <= pend_cnt_in;
            pend_digit_ff <= pend_digit_in;
            inv_cnt_ff    <= inv_cnt_in;
         end
         if (csr_wr_en) begin
            separator_ff <= csr_wr_data;
         end
      end
   end

endmodule

### src/qspd_queue.sv
// short queue of result bundles between front and back
module qspd_queue #(
   parameter int DEPTH = qspd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  qspd_pkg::bundle_type        push_data,
   input  logic                        pop,
   output qspd_pkg::bundle_type        head,
   output qspd_pkg::queue_status_type  status
);

   localparam int PTR_BITS = $clog2(DEPTH);

   qspd_pkg::bundle_type  mem_ff [DEPTH];
   logic [PTR_BITS:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS:0]     rd_ptr_ff, rd_ptr_in;

   // extra pointer bit tells full from empty
   assign status.empty = (wr_ptr_ff == rd_ptr_ff);
   assign status.full  = (wr_ptr_ff[PTR_BITS] != rd_ptr_ff[PTR_BITS]) &&
                         (wr_ptr_ff[PTR_BITS-1:0] == rd_ptr_ff[PTR_BITS-1:0]);
   assign head         = mem_ff[rd_ptr_ff[PTR_BITS-1:0]];

   assign wr_ptr_in = wr_ptr_ff + (PTR_BITS + 1)'(1);
   assign rd_ptr_in = rd_ptr_ff + (PTR_BITS + 1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push && !status.full) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop && !status.empty) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push && !status.full) begin
         mem_ff[wr_ptr_ff[PTR_BITS-1:0]] <= push_data;
      end
   end

endmodule

### src/qspd_back.sv
// back end: walks each bundle and drives results through the output register
module qspd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  qspd_pkg::bundle_type        head,
   input  qspd_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_kind,
   output logic [7:0]                  rsp_out_byte,
   output logic [15:0]                 rsp_invalid_count,
   output logic                        rsp_last_of_run
);

   localparam int IDX_BITS = qspd_pkg::RESULT_IDX_BITS;

   logic [qspd_pkg::RESULT_IDX_BITS-1:0] idx_ff, idx_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]                           rsp_kind_ff;
   logic [7:0]                           rsp_out_byte_ff;
   logic [15:0]                          rsp_invalid_count_ff;
   logic                                 rsp_last_of_run_ff;
   logic                                 load;
   logic                                 final_res;
   qspd_pkg::result_type                 cur;

   assign load      = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign cur       = head.res[idx_ff];
   assign final_res = (idx_ff == (head.num - IDX_BITS'(1)));
   assign pop       = load && final_res;
   assign idx_in    = final_res ? '0 : idx_ff + IDX_BITS'(1);
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff          <= cur.kind;
         rsp_out_byte_ff      <= cur.data;
         rsp_invalid_count_ff <= cur.count;
         rsp_last_of_run_ff   <= final_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_out_byte      = rsp_out_byte_ff;
   assign rsp_invalid_count = rsp_invalid_count_ff;
   assign rsp_last_of_run   = rsp_last_of_run_ff;

endmodule

### src/qspd_checker.sv
// port-level checks for the query string percent decoder and their bind
module qspd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_in_byte,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_out_byte,
   input logic [15:0] rsp_invalid_count,
   input logic        rsp_last_of_run,
   input logic        csr_wr_en,
   input logic [7:0]  csr_wr_data
);

   // a stalled result transfer keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) &&
                                 $stable(rsp_invalid_count) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // done always ends the run of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == qspd_pkg::KIND_DONE) |-> rsp_last_of_run)
      else $error("done result not last of run");

   // markers carry no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == qspd_pkg::KIND_END) || (rsp_kind == qspd_pkg::KIND_DONE))
      |-> (rsp_out_byte == 8'd0))
      else $error("marker result with nonzero byte");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind query_string_percent_decoder_unit qspd_checker u_checker (.*);

### sim/tb_query_string_percent_decoder_unit.sv
// testbench for the query string percent decoder: directed strings and random queries
`timescale 1ns / 100ps

typedef enum logic [1:0] {AWAIT_KEY, IN_KEY, IN_VALUE} parse_mode_type;

typedef struct packed {
   logic [1:0]  kind;
   logic [7:0]  data;
   logic [15:0] count;
   logic        closing;
} decoded_type;

class decode_scoreboard;
   logic [7:0]     separator;
   parse_mode_type mode;
   int unsigned    pend_n;
   logic [7:0]     pend_digit;
   logic [15:0]    bad_escapes;
   decoded_type    burst[$];
   decoded_type    expected_q[$];
   int unsigned    errors;
   int unsigned    bytes_in;
   int unsigned    results_out;

   function new();
      separator   = qspd_pkg::SEPARATOR_RESET;
      mode        = AWAIT_KEY;
      pend_n      = 0;
      pend_digit  = 8'h00;
      bad_escapes = 16'h0000;
      errors      = 0;
      bytes_in    = 0;
      results_out = 0;
   endfunction

   function void push(logic [1:0] kind, logic [7:0] data);
      decoded_type d;
      d.kind    = kind;
      d.data    = data;
      d.count   = bad_escapes;
      d.closing = 1'b0;
      burst.insert(burst.size(), d);
   endfunction

   function logic [1:0] byte_kind();
      return (mode == IN_VALUE) ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_KEY;
   endfunction

   function bit hex_digit(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function logic [3:0] hex_value(logic [7:0] c);
      logic [7:0] v;
      if (c <= "9") begin
         v = c - "0";
      end else if (c >= "a") begin
         v = c - "a" + 8'd10;
      end else begin
         v = c - "A" + 8'd10;
      end
      return v[3:0];
   endfunction

   // unfinished escape: raw percent plus any held digit, counted once
   function void broken_escape();
      if (pend_n != 0) begin
         if (bad_escapes != 16'hffff) begin
            bad_escapes++;
         end
         push(byte_kind(), qspd_pkg::CHAR_PERCENT);
         if (pend_n >= 2) begin
            push(byte_kind(), pend_digit);
         end
      end
      pend_n     = 0;
      pend_digit = 8'h00;
   endfunction

   function void literal(logic [7:0] c);
      if (c == qspd_pkg::CHAR_PERCENT) begin
         pend_n = 1;
      end else if (c == qspd_pkg::CHAR_PLUS) begin
         push(byte_kind(), qspd_pkg::CHAR_SPACE);
      end else begin
         push(byte_kind(), c);
      end
   endfunction

   function void note_byte(logic [7:0] c, logic last);
      bit seg_end;
      bit used;
      bytes_in++;
      if (mode == AWAIT_KEY) begin
         pend_n = 0;
         if (c == separator) begin
         end else if (c == qspd_pkg::CHAR_EQUAL) begin
            mode = IN_VALUE;
         end else begin
            mode = IN_KEY;
            literal(c);
         end
      end else begin
         seg_end = (c == separator) || (mode == IN_KEY && c == qspd_pkg::CHAR_EQUAL);
         used    = 0;
         if (pend_n == 1) begin
            if (!seg_end && hex_digit(c)) begin
               pend_n     = 2;
               pend_digit = c;
               used       = 1;
            end else begin
               broken_escape();
            end
         end else if (pend_n >= 2) begin
            if (!seg_end && hex_digit(c)) begin
               push(byte_kind(), {hex_value(pend_digit), hex_value(c)});
               pend_n     = 0;
               pend_digit = 8'h00;
               used       = 1;
            end else begin
               broken_escape();
            end
         end
         if (!used) begin
            if (c == separator) begin
               push(qspd_pkg::KIND_END, 8'h00);
               mode = AWAIT_KEY;
            end else if (mode == IN_KEY && c == qspd_pkg::CHAR_EQUAL) begin
               mode = IN_VALUE;
            end else begin
               literal(c);
            end
         end
      end
      if (last) begin
         broken_escape();
         if (mode != AWAIT_KEY) begin
            push(qspd_pkg::KIND_END, 8'h00);
         end
         push(qspd_pkg::KIND_DONE, 8'h00);
         bad_escapes = 16'h0000;
         mode        = AWAIT_KEY;
      end
      if (burst.size() > 0) begin
         burst[burst.size()-1].closing = 1'b1;
      end
      foreach (burst[i]) begin
         expected_q.insert(expected_q.size(), burst[i]);
      end
      burst.delete();
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
      end
   endfunction

   function void check_result(logic [1:0] kind, logic [7:0] data, logic [15:0] count,
                              logic closing);
      decoded_type want;
      results_out++;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: result with nothing expected, expected none got kind %0d byte %h count %0d",
                  $time, kind, data, count);
         return;
      end
      want = expected_q.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("out_byte", want.data, data);
      compare_field("invalid_count", want.count, count);
      compare_field("last_of_run", want.closing, closing);
   endfunction
endclass

module tb_query_string_percent_decoder_unit;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_last    = 1'b0;
   logic        rsp_stall   = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_out_byte;
   logic [15:0] rsp_invalid_count;
   logic        rsp_last_of_run;

   decode_scoreboard sb;
   logic [7:0]       text_q[$];
   int               send_quiet    = 0;
   int               take_quiet    = 0;
   int               settings_used = 0;

   query_string_percent_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_invalid_count (rsp_invalid_count),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // occasional stretches with no idling at all
   function automatic int pick_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet = $urandom_range(5, 30);
      end
      return $urandom_range(0, 13);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_last    <= last;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, last);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
      end
      text_q.delete();
   endtask

   function automatic void append_byte(logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         append_byte(s[i]);
      end
   endfunction

   function automatic void push_hex();
      string hexset = "0123456789abcdefABCDEF";
      append_byte(hexset[$urandom_range(0, hexset.len() - 1)]);
   endfunction

   function automatic void push_token(logic [7:0] sep);
      string alnum = "abxyzKQ059_-.~";
      int    pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         append_byte(alnum[$urandom_range(0, alnum.len() - 1)]);
      end else if (pick < 50) begin
         append_byte(qspd_pkg::CHAR_PLUS);
      end else if (pick < 65) begin
         append_byte(qspd_pkg::CHAR_PERCENT);
         push_hex();
         push_hex();
      end else if (pick < 72) begin
         // likely broken escape
         append_byte(qspd_pkg::CHAR_PERCENT);
         if ($urandom_range(0, 1) == 1) begin
            push_hex();
         end
         append_byte(8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
         append_byte(qspd_pkg::CHAR_EQUAL);
      end else if (pick < 85) begin
         append_byte(sep);
      end else begin
         append_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void build_query(logic [7:0] sep);
      int n_args;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
         return;
      end
      n_args = $urandom_range(1, 4);
      for (int a = 0; a < n_args; a++) begin
         if ($urandom_range(0, 3) == 0) begin
            append_byte(sep);
         end
         repeat ($urandom_range(0, 3)) push_token(sep);
         if ($urandom_range(0, 3) != 0) begin
            append_byte(qspd_pkg::CHAR_EQUAL);
            repeat ($urandom_range(0, 4)) push_token(sep);
         end
         if (a < n_args - 1 || $urandom_range(0, 4) == 0) begin
            append_byte(sep);
         end
      end
      if (text_q.size() == 0) begin
         append_byte("a");
      end
   endfunction

   // wait for every expected result, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      sb.separator  = value;
      settings_used++;
   endtask

   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = pick_gap(take_quiet);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_kind, rsp_out_byte, rsp_invalid_count, rsp_last_of_run);
      end
   end

   initial begin
      logic [7:0] seps[7];
      int unsigned start;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed strings under the reset separator
      add_text("&k+%4a%C3%=v=%z");
      append_byte(8'h00);
      send_text();
      add_text("=%F");
      send_text();
      append_byte(8'hff);
      add_text("=%4z");
      send_text();
      add_text("q&&");
      send_text();

      seps = '{8'h00, 8'hff, qspd_pkg::CHAR_EQUAL, qspd_pkg::CHAR_PERCENT, 8'h3b,
               8'($urandom_range(0, 255)), qspd_pkg::SEPARATOR_RESET};
      foreach (seps[p]) begin
         settle();
         write_separator(seps[p]);
         start = sb.bytes_in;
         while (sb.bytes_in - start < 16) begin
            build_query(seps[p]);
            send_text();
         end
      end

      settle();
      repeat (12) @(posedge clock);
      $display("covered %0d input bytes and %0d results over %0d separator settings,",
               sb.bytes_in, sb.results_out, settings_used);
      $display("including directed corner strings and random stalls on both sides");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout, %0d results still outstanding", sb.expected_q.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
